// File: rtl/byte_range_header_parser_assert.svh
// ----------------------------------------------------------------------------
// Byte-range header parser assertion macros
// Clocked property wrappers for the RTL file that checks itself.
// ----------------------------------------------------------------------------
`ifndef BYTE_RANGE_HEADER_PARSER_ASSERT_SVH
`define BYTE_RANGE_HEADER_PARSER_ASSERT_SVH

// Same-cycle implication, masked while reset is asserted.
`define BRHP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define BRHP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/brhp_pkg.sv
// ----------------------------------------------------------------------------
// Byte-range header parser package
// Character codes, parser codes, state types and the decimal accumulator step.
// ----------------------------------------------------------------------------
package brhp_pkg;

    localparam int unsigned CHAR_W     = 8;
    localparam int unsigned VAL_W      = 64;
    localparam int unsigned PREFIX_LEN = 6;
    localparam int unsigned POS_W      = $clog2(PREFIX_LEN + 1);
    localparam int unsigned WIDE_W     = VAL_W + 4;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
    localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    localparam logic [VAL_W-1:0] SIGN_BIT = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic [VAL_W-1:0] INT_MAX  = {1'b0, {(VAL_W-1){1'b1}}};

    // Parser phase codes
    localparam logic [1:0] PH_PREFIX = 2'd0;
    localparam logic [1:0] PH_BLANKS = 2'd1;
    localparam logic [1:0] PH_BODY   = 2'd2;

    // Number reader stage codes
    localparam logic [1:0] NS_WAIT   = 2'd0;
    localparam logic [1:0] NS_SIGNED = 2'd1;
    localparam logic [1:0] NS_DIGITS = 2'd2;
    localparam logic [1:0] NS_DONE   = 2'd3;

    typedef struct packed {
        logic [VAL_W-1:0] mag;
        logic             neg;
        logic             has_dig;
        logic             ovf;
        logic [1:0]       stage;
    } t_num;

    typedef struct packed {
        logic       ok0;
        t_num       front;
        t_num       back;
    } t_snap;

    function automatic logic [CHAR_W-1:0] prefix_char(input logic [POS_W-1:0] pos);
        logic [CHAR_W-1:0] ch;
        unique case (pos)
            3'd0:    ch = 8'h62;  // b
            3'd1:    ch = 8'h79;  // y
            3'd2:    ch = 8'h74;  // t
            3'd3:    ch = 8'h65;  // e
            3'd4:    ch = 8'h73;  // s
            3'd5:    ch = 8'h3D;  // =
            default: ch = CH_NUL;
        endcase
        return ch;
    endfunction

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
               (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
    endfunction

    // One character into a strtoll-style decimal reader.
    function automatic t_num num_feed(input logic [CHAR_W-1:0] c, input t_num s);
        t_num              r;
        logic              is_dig;
        logic              take;
        logic [WIDE_W-1:0] wide;
        r      = s;
        is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
        take   = 1'b0;
        unique case (s.stage)
            NS_WAIT: begin
                if (!is_space(c)) begin
                    if (c == CH_PLUS || c == CH_DASH) begin
                        r.neg   = (c == CH_DASH);
                        r.stage = NS_SIGNED;
                    end else begin
                        r.stage = is_dig ? NS_DIGITS : NS_DONE;
                        take    = is_dig;
                    end
                end
            end
            NS_SIGNED: begin
                r.stage = is_dig ? NS_DIGITS : NS_DONE;
                take    = is_dig;
            end
            NS_DIGITS: begin
                if (is_dig) begin
                    take = 1'b1;
                end else begin
                    r.stage = NS_DONE;
                end
            end
            default: ;
        endcase
        // mag*10 + d as shifts; above 2^63 saturates
        wide = ({4'b0, s.mag} << 3) + ({4'b0, s.mag} << 1)
             + {{(WIDE_W-CHAR_W){1'b0}}, c - CH_ZERO};
        if (take) begin
            r.has_dig = 1'b1;
            if (s.ovf || wide > {4'b0, SIGN_BIT}) begin
                r.ovf = 1'b1;
                r.mag = SIGN_BIT;
            end else begin
                r.mag = wide[VAL_W-1:0];
            end
        end
        return r;
    endfunction

    // Signed two's complement value of a reader, saturated.
    function automatic logic [VAL_W-1:0] num_value(input t_num s);
        logic [VAL_W-1:0] v;
        if (s.neg) begin
            v = (s.ovf || s.mag[VAL_W-1]) ? SIGN_BIT : (~s.mag + 1'b1);
        end else begin
            v = (s.ovf || s.mag[VAL_W-1]) ? INT_MAX : s.mag;
        end
        return v;
    endfunction

endpackage

// File: rtl/brhp_if.sv
// ----------------------------------------------------------------------------
// Byte-range header parser channels
// Valid/ready request channels for header bytes and for parsed ranges.
// ----------------------------------------------------------------------------
interface brhp_in_if;
    logic                         valid;
    logic                         ready;
    logic [brhp_pkg::CHAR_W-1:0]  char_code;
    logic                         last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface brhp_out_if;
    logic                               valid;
    logic                               ready;
    logic                               range_valid;
    logic signed [brhp_pkg::VAL_W-1:0]  range_start;
    logic signed [brhp_pkg::VAL_W-1:0]  range_end;

    modport source (output valid, output range_valid, output range_start,
                    output range_end, input ready);
    modport sink   (input valid, input range_valid, input range_start,
                    input range_end, output ready);
endinterface

// File: rtl/brhp_parse.sv
// ----------------------------------------------------------------------------
// Byte-range header parser: character stage
// Tracks prefix, blanks, dash and both decimal readers, one byte per cycle while i_go is high.
// ----------------------------------------------------------------------------
module brhp_parse (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_go,
    input  logic [brhp_pkg::CHAR_W-1:0]  i_char,
    input  logic                         i_last,
    output brhp_pkg::t_snap              o_snap
);
    import brhp_pkg::*;

    logic [POS_W-1:0] r_pos,    n_pos;
    logic [1:0]       r_phase,  n_phase;
    logic             r_failed, n_failed;
    logic             r_ended,  n_ended;
    logic             r_dash,   n_dash;
    t_num             r_front,  n_front;
    t_num             r_back,   n_back;

    always_comb begin
        n_pos    = r_pos;
        n_phase  = r_phase;
        n_failed = r_failed;
        n_ended  = r_ended;
        n_dash   = r_dash;
        n_front  = r_front;
        n_back   = r_back;
        if (!r_failed && !r_ended) begin
            if (i_char == CH_NUL) begin
                n_ended  = 1'b1;
                n_failed = (r_phase != PH_BODY);
            end else begin
                unique case (r_phase)
                    PH_PREFIX: begin
                        if (r_pos < POS_W'(PREFIX_LEN) && i_char == prefix_char(r_pos)) begin
                            n_pos = r_pos + 1'b1;
                            if (n_pos == POS_W'(PREFIX_LEN)) begin
                                n_phase = PH_BLANKS;
                            end
                        end else begin
                            n_failed = 1'b1;
                        end
                    end
                    PH_BLANKS: begin
                        if (i_char == CH_DASH) begin
                            n_failed = 1'b1;
                        end else if (i_char != CH_SPACE && i_char != CH_TAB) begin
                            n_phase = PH_BODY;
                        end
                    end
                    default: ;
                endcase
                // first body byte is read in the same cycle it opens the body
                if (n_phase == PH_BODY && !n_failed) begin
                    n_front = num_feed(i_char, r_front);
                    if (r_dash) begin
                        n_back = num_feed(i_char, r_back);
                    end else if (i_char == CH_DASH) begin
                        n_dash = 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        o_snap.ok0   = !n_failed && (n_phase == PH_BODY) && n_dash && n_front.has_dig;
        o_snap.front = n_front;
        o_snap.back  = n_back;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_go && i_last)) begin
            r_pos    <= '0;
            r_phase  <= PH_PREFIX;
            r_failed <= 1'b0;
            r_ended  <= 1'b0;
            r_dash   <= 1'b0;
            r_front  <= '0;
            r_back   <= '0;
        end else if (i_go) begin
            r_pos    <= n_pos;
            r_phase  <= n_phase;
            r_failed <= n_failed;
            r_ended  <= n_ended;
            r_dash   <= n_dash;
            r_front  <= n_front;
            r_back   <= n_back;
        end
    end

endmodule

// File: rtl/brhp_finish.sv
// ----------------------------------------------------------------------------
// Byte-range header parser: result stages
// Saturates both numbers, then checks their order and forms the exclusive end.
// ----------------------------------------------------------------------------
module brhp_finish (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  brhp_pkg::t_snap   i_snap,
    output logic              o_ready,
    brhp_out_if.source        o_out
);
    import brhp_pkg::*;

    logic                    r_v_valid;
    logic                    r_v_ok0;
    logic signed [VAL_W-1:0] r_v_front;
    logic signed [VAL_W-1:0] r_v_back;
    logic                    v_go;
    logic                    range_ok;

    logic                    r_o_valid;
    logic                    r_o_range_valid;
    logic signed [VAL_W-1:0] r_o_start;
    logic signed [VAL_W-1:0] r_o_end;

    assign v_go    = r_v_valid && (!r_o_valid || o_out.ready);
    assign o_ready = !r_v_valid || v_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_valid <= 1'b0;
        end else if (o_ready) begin
            r_v_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_ready) begin
            r_v_ok0   <= i_snap.ok0;
            r_v_front <= num_value(i_snap.front);
            // open end reads as the maximum
            r_v_back  <= i_snap.back.has_dig ? num_value(i_snap.back) : INT_MAX;
        end
    end

    assign range_ok = r_v_ok0 && (r_v_front <= r_v_back);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (!r_o_valid || o_out.ready) begin
            r_o_valid <= r_v_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (v_go) begin
            r_o_range_valid <= range_ok;
            if (range_ok) begin
                r_o_start <= r_v_front;
                r_o_end   <= (r_v_back == INT_MAX) ? INT_MAX : (r_v_back + 1'b1);
            end else begin
                r_o_start <= '1;
                r_o_end   <= '1;
            end
        end
    end

    assign o_out.valid       = r_o_valid;
    assign o_out.range_valid = r_o_range_valid;
    assign o_out.range_start = r_o_start;
    assign o_out.range_end   = r_o_end;

endmodule

// File: rtl/byte_range_header_parser.sv
// ----------------------------------------------------------------------------
// Byte-range header parser
// Reads a "bytes=" range header byte by byte and gives one range per header.
//
//   channel  | dir | request            | moves on
//   ---------+-----+--------------------+---------------------------------
//   i_in     | in  | one header byte    | valid && ready
//   o_out    | out | one parsed range   | valid && ready, once per last byte
//
// One byte is taken every cycle unless a final byte stalls i_in; the per-byte step is the x10 accumulator.
// The range for a header moves through the registers after its last byte is taken:
// the byte sits in the input register, the character logic and saturation load
// the value register, then ordering loads the output register.
// Reset (i_rst_n low, synchronous) empties the stages and clears the parser.
// A stalled output holds its range and the value register fills behind it; a
// final byte then waits in the input register and i_in stalls. Other bytes flow.
// ----------------------------------------------------------------------------
`include "byte_range_header_parser_assert.svh"

module byte_range_header_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    brhp_in_if.sink     i_in,
    brhp_out_if.source  o_out
);
    import brhp_pkg::*;

    logic              r_in_valid;
    logic [CHAR_W-1:0] r_char;
    logic              r_last;
    logic              parse_go;
    logic              fin_ready;
    t_snap             snap;

    // non-final bytes never wait on the result side
    assign parse_go   = r_in_valid && (!r_last || fin_ready);
    assign i_in.ready = !r_in_valid || parse_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready) begin
            r_char <= i_in.char_code;
            r_last <= i_in.last_char;
        end
    end

    brhp_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (parse_go),
        .i_char  (r_char),
        .i_last  (r_last),
        .o_snap  (snap)
    );

    brhp_finish u_finish (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (parse_go && r_last),
        .i_snap  (snap),
        .o_ready (fin_ready),
        .o_out   (o_out)
    );

    `BRHP_ASSERT_NOW(a_fail_all_ones, i_clk, i_rst_n,
        o_out.valid && !o_out.range_valid,
        (o_out.range_start == '1) && (o_out.range_end == '1),
        "failed range must read -1,-1")

    `BRHP_ASSERT_NOW(a_range_ordered, i_clk, i_rst_n,
        o_out.valid && o_out.range_valid,
        o_out.range_start <= o_out.range_end,
        "valid range has start beyond end")

    `BRHP_ASSERT_NEXT(a_last_waits, i_clk, i_rst_n,
        r_in_valid && r_last && !fin_ready,
        r_in_valid && r_last,
        "final byte dropped while result stages were full")

endmodule
